@@ sv/dss_pkg.sv @@
// Shared types, constants and helpers for the two-stack shared-array block.
`default_nettype none

package dss_pkg;

    localparam int DEPTH       = 16;
    localparam int AW          = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW          = $clog2(DEPTH + 1);
    localparam int DW          = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QAW         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

    typedef logic [AW-1:0] t_addr;
    typedef logic [CW-1:0] t_cnt;
    typedef logic [DW-1:0] t_word;
    typedef logic [1:0]    t_status;

    localparam t_status STATUS_OK    = 2'd0;
    localparam t_status STATUS_FULL  = 2'd1;
    localparam t_status STATUS_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        CMD_PUSH  = 3'd0,
        CMD_POP   = 3'd1,
        CMD_PEEK  = 3'd2,
        CMD_QUERY = 3'd3,
        CMD_LIST  = 3'd4
    } t_cmd;

    typedef struct packed {
        t_cmd  op;
        logic  sel;
        t_word value;
    } t_entry;

    // Store address of entry pos (0 is the bottom) of the selected stack.
    function automatic t_addr slot(input logic sel, input t_cnt pos);
        t_addr p;
        p = AW'(pos);
        return sel ? (AW'(DEPTH - 1) - p) : p;
    endfunction

endpackage

`default_nettype wire

@@ sv/dss_front.sv @@
// Front end: accepts commands and forwards the valid ones to the command queue.
`default_nettype none

module dss_front (
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic [2:0]      i_cmd,
    input  wire logic            i_stack_sel,
    input  wire logic [31:0]     i_push_value,
    output logic                 o_q_valid,
    input  wire logic            i_q_ready,
    output dss_pkg::t_entry      o_q_data
);
    import dss_pkg::*;

    logic known;

    always_comb begin
        unique case (i_cmd) inside
            CMD_PUSH, CMD_POP, CMD_PEEK, CMD_QUERY, CMD_LIST: known = 1'b1;
            default: known = 1'b0;
        endcase
    end

    // Unknown codes are still taken from the channel but cause no work.
    assign o_in_ready     = i_q_ready;
    assign o_q_valid      = i_in_valid && known;
    assign o_q_data.op    = t_cmd'(i_cmd);
    assign o_q_data.sel   = i_stack_sel;
    assign o_q_data.value = i_push_value;

endmodule

`default_nettype wire

@@ sv/dss_queue.sv @@
// Short command queue between the front end and the execution unit.
`default_nettype none

module dss_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_wr_valid,
    output logic                 o_wr_ready,
    input  dss_pkg::t_entry      i_wr_data,
    output logic                 o_rd_valid,
    input  wire logic            i_rd_ready,
    output dss_pkg::t_entry      o_rd_data
);
    import dss_pkg::*;

    t_entry         r_mem [QUEUE_DEPTH];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QCW-1:0] r_count;
    logic           wr_en;
    logic           rd_en;

    assign o_wr_ready = (r_count != QCW'(QUEUE_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign wr_en      = i_wr_valid && o_wr_ready;
    assign rd_en      = i_rd_ready && o_rd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

`default_nettype wire

@@ sv/dss_back.sv @@
// Execution unit: holds the shared store and both stack counts and produces results.
`default_nettype none

module dss_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_valid,
    output logic                 o_q_ready,
    input  dss_pkg::t_entry      i_q_data,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output logic [1:0]           o_status,
    output logic signed [31:0]   o_data,
    output logic                 o_empty_flag,
    output logic                 o_last
);
    import dss_pkg::*;

    typedef enum logic {
        ST_RUN,
        ST_LIST
    } t_state;

    t_word   r_store [DEPTH];
    t_state  r_state, n_state;
    t_cnt    r_lower, n_lower;
    t_cnt    r_upper, n_upper;
    t_cnt    r_idx, n_idx;
    logic    r_lsel, n_lsel;
    logic    r_out_valid;
    t_status r_status, n_status;
    t_word   r_data;
    logic    r_empty, n_empty;
    logic    r_last, n_last;

    logic    load_ok;
    logic    load;
    logic    use_mem;
    t_addr   rd_addr;
    logic    wr_en;
    t_addr   wr_addr;
    t_cnt    cnt;
    t_cnt    list_cnt;
    logic    full;

    assign load_ok  = !r_out_valid || i_out_ready;
    assign cnt      = i_q_data.sel ? r_upper : r_lower;
    assign list_cnt = r_lsel ? r_upper : r_lower;
    assign full     = ({1'b0, r_lower} + {1'b0, r_upper}) >= (CW + 1)'(DEPTH);

    always_comb begin
        n_state   = r_state;
        n_lower   = r_lower;
        n_upper   = r_upper;
        n_idx     = r_idx;
        n_lsel    = r_lsel;
        n_status  = STATUS_OK;
        n_empty   = 1'b0;
        n_last    = 1'b1;
        o_q_ready = 1'b0;
        load      = 1'b0;
        use_mem   = 1'b0;
        rd_addr   = '0;
        wr_en     = 1'b0;
        wr_addr   = '0;
        unique case (r_state)
            ST_RUN: begin
                if (i_q_valid && load_ok) begin
                    o_q_ready = 1'b1;
                    load      = 1'b1;
                    unique case (i_q_data.op)
                        CMD_PUSH: begin
                            if (full) begin
                                n_status = STATUS_FULL;
                                n_empty  = (cnt == '0);
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = slot(i_q_data.sel, cnt);
                                if (i_q_data.sel) begin
                                    n_upper = r_upper + 1'b1;
                                end else begin
                                    n_lower = r_lower + 1'b1;
                                end
                            end
                        end
                        CMD_POP: begin
                            if (cnt == '0) begin
                                n_status = STATUS_EMPTY;
                                n_empty  = 1'b1;
                            end else begin
                                use_mem = 1'b1;
                                rd_addr = slot(i_q_data.sel, cnt - 1'b1);
                                n_empty = (cnt == CW'(1));
                                if (i_q_data.sel) begin
                                    n_upper = r_upper - 1'b1;
                                end else begin
                                    n_lower = r_lower - 1'b1;
                                end
                            end
                        end
                        CMD_PEEK: begin
                            if (cnt == '0) begin
                                n_status = STATUS_EMPTY;
                                n_empty  = 1'b1;
                            end else begin
                                use_mem = 1'b1;
                                rd_addr = slot(i_q_data.sel, cnt - 1'b1);
                            end
                        end
                        CMD_QUERY: begin
                            n_empty = (cnt == '0);
                        end
                        CMD_LIST: begin
                            if (cnt == '0) begin
                                n_status = STATUS_EMPTY;
                                n_empty  = 1'b1;
                            end else begin
                                load    = 1'b0;
                                n_state = ST_LIST;
                                n_idx   = '0;
                                n_lsel  = i_q_data.sel;
                            end
                        end
                        default: begin
                            load = 1'b0;
                        end
                    endcase
                end
            end
            ST_LIST: begin
                if (load_ok) begin
                    load    = 1'b1;
                    use_mem = 1'b1;
                    rd_addr = slot(r_lsel, r_idx);
                    n_last  = ((r_idx + 1'b1) == list_cnt);
                    if (n_last) begin
                        n_state = ST_RUN;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_lower     <= '0;
            r_upper     <= '0;
            r_idx       <= '0;
            r_lsel      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lower <= n_lower;
            r_upper <= n_upper;
            r_idx   <= n_idx;
            r_lsel  <= n_lsel;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (load) begin
            r_status <= n_status;
            r_empty  <= n_empty;
            r_last   <= n_last;
            r_data   <= use_mem ? r_store[rd_addr] : '0;
        end
        if (wr_en) begin
            r_store[wr_addr] <= i_q_data.value;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_data       = signed'(r_data);
    assign o_empty_flag = r_empty;
    assign o_last       = r_last;

endmodule

`default_nettype wire

@@ sv/dual_stack_shared_array.sv @@
// Top level of the two-stack shared-array block.
// Commands arrive on the input channel (i_in_valid / o_in_ready) with a command code,
// a stack select and a push value; a transfer takes place when valid and ready are
// both high at a rising edge. Results leave on the output channel (o_out_valid /
// i_out_ready) with status, data, empty flag and a last marker.
// Stack 0 fills the store from the bottom and stack 1 from the top of the store.
// A command is written into a two-entry queue at its input transfer; the execution
// unit takes it from the queue and registers its first result in the output
// register, from which that result can itself transfer.
// Push, pop and peek take at most one store access, query none, and each gives
// one result; while the output is not stalled the execution unit finishes one
// of them per cycle. A list of n entries takes a set-up step and then one store
// read per cycle while the output is not stalled, and holds the queue until its
// last entry is out. Unknown command codes are taken and dropped without a result.
// When the receiver stalls, the result waits in the output register and the
// queue keeps accepting commands until it holds two.
// A synchronous active-low reset empties both stacks, the queue and the output
// register; store contents are not cleared.
`default_nettype none

module dual_stack_shared_array (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [2:0]          i_cmd,
    input  wire logic                i_stack_sel,
    input  wire logic signed [31:0]  i_push_value,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [1:0]               o_status,
    output logic signed [31:0]       o_data,
    output logic                     o_empty_flag,
    output logic                     o_last
);
    import dss_pkg::*;

    logic   fq_valid;
    logic   fq_ready;
    t_entry fq_data;
    logic   qb_valid;
    logic   qb_ready;
    t_entry qb_data;

    dss_front u_front (
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_stack_sel  (i_stack_sel),
        .i_push_value (unsigned'(i_push_value)),
        .o_q_valid    (fq_valid),
        .i_q_ready    (fq_ready),
        .o_q_data     (fq_data)
    );

    dss_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (fq_valid),
        .o_wr_ready (fq_ready),
        .i_wr_data  (fq_data),
        .o_rd_valid (qb_valid),
        .i_rd_ready (qb_ready),
        .o_rd_data  (qb_data)
    );

    dss_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (qb_valid),
        .o_q_ready    (qb_ready),
        .i_q_data     (qb_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_data       (o_data),
        .o_empty_flag (o_empty_flag),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire
